>>> sv/mau_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mau_pkg
// Types and constants shared by the modular arithmetic unit.
// ---------------------------------------------------------------------------
package mau_pkg;

  localparam int unsigned RES_W  = 31;   // internal residue width
  localparam int unsigned OUT_W  = 30;   // residue field width
  localparam int unsigned OPND_W = 30;
  localparam int unsigned RAW_W  = 32;
  localparam int unsigned EXP_W  = 31;
  localparam int unsigned MPL_W  = 32;   // multiplier operand width, bits scanned per product
  localparam int unsigned CNT_W  = 6;

  typedef enum logic [3:0] {
    FN_REDUCE  = 4'd0,
    FN_ADD     = 4'd1,
    FN_SUB     = 4'd2,
    FN_MUL     = 4'd3,
    FN_DIV     = 4'd4,
    FN_INVERSE = 4'd5,
    FN_POWER   = 4'd6,
    FN_LESS    = 4'd7,
    FN_EQUAL   = 4'd8
  } func_t;

  typedef enum logic [2:0] {
    MS_RED_A,
    MS_RED_B,
    MS_RED_RAW,
    MS_AB,
    MS_ACC_P,
    MS_P_P,
    MS_A_ACC
  } mul_sel_t;

  typedef enum logic [2:0] {
    RS_ACC,
    RS_RAW,
    RS_ADD,
    RS_SUB,
    RS_LESS,
    RS_EQUAL,
    RS_ZERO
  } res_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_RED_RAW,
    ST_MUL_AB,
    ST_POW_INIT,
    ST_POW_STEP,
    ST_POW_SQR,
    ST_DIV_MUL,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     pow_init;
    logic     pow_base_b;
    logic     pow_exp_fermat;
    logic     e_shift;
    logic     out_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic e_zero;
    logic e_lsb;
  } status_t;

endpackage
`default_nettype wire

>>> sv/mau_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mau_datapath
// Operand registers, bit-serial modular multiplier, exponent register and
// result register of the modular arithmetic unit.
// ---------------------------------------------------------------------------
module mau_datapath #(
  parameter int unsigned MODULUS = 998244353
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [29:0]                operand_a,
  input  wire logic [29:0]                operand_b,
  input  wire logic signed [31:0]         raw_integer,
  input  wire logic [30:0]                exponent,
  input  wire mau_pkg::cmd_t              cmd,
  output mau_pkg::status_t                status,
  output logic [29:0]                     residue,
  output logic                            compare_flag
);
  import mau_pkg::*;

  localparam logic [RES_W-1:0] MOD_R   = RES_W'(MODULUS);
  localparam logic [MPL_W-1:0] MOD_M   = MPL_W'(MODULUS);
  localparam logic [EXP_W-1:0] FERMAT  = EXP_W'(MODULUS - 2);
  localparam logic [RES_W-1:0] ONE     = RES_W'(1);

  logic [OPND_W-1:0] a_in, b_in;
  logic [RAW_W-1:0]  raw;
  logic [EXP_W-1:0]  e_in, e_reg;
  logic [RES_W-1:0]  a_r, b_r, acc, p;

  logic [RES_W-1:0]  mcand, r;
  logic [MPL_W-1:0]  mplier;
  logic [CNT_W-1:0]  cnt;
  logic              busy, done;
  mul_sel_t          sel_q;

  logic [RES_W-1:0]  mcand_sel;
  logic [MPL_W-1:0]  mplier_sel, abs_raw, r2, r2c, t, tc;

  logic [MPL_W-1:0]  sum_ab, sub_ab;
  logic [RES_W-1:0]  res_mux;
  logic              flag_mux;

  assign abs_raw = raw[RAW_W-1] ? (~raw + MPL_W'(1)) : raw;

  always_comb begin
    mcand_sel  = ONE;
    mplier_sel = '0;
    case (cmd.mul_sel)
      MS_RED_A:   mplier_sel = MPL_W'(a_in);
      MS_RED_B:   mplier_sel = MPL_W'(b_in);
      MS_RED_RAW: mplier_sel = abs_raw;
      MS_AB:      begin mcand_sel = a_r; mplier_sel = MPL_W'(b_r); end
      MS_ACC_P:   begin mcand_sel = p;   mplier_sel = MPL_W'(acc); end
      MS_P_P:     begin mcand_sel = p;   mplier_sel = MPL_W'(p);   end
      MS_A_ACC:   begin mcand_sel = a_r; mplier_sel = MPL_W'(acc); end
      default:    mplier_sel = '0;
    endcase
  end

  // one multiplier bit a cycle: double, correct, add, correct
  always_comb begin
    r2  = {r, 1'b0};
    r2c = (r2 >= MOD_M) ? r2 - MOD_M : r2;
    t   = r2c + (mplier[MPL_W-1] ? MPL_W'(mcand) : '0);
    tc  = (t >= MOD_M) ? t - MOD_M : t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.mul_start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_in <= operand_a;
      b_in <= operand_b;
      raw  <= raw_integer;
      e_in <= exponent;
    end
    if (cmd.mul_start) begin
      mcand  <= mcand_sel;
      mplier <= mplier_sel;
      r      <= '0;
      cnt    <= CNT_W'(MPL_W);
      sel_q  <= cmd.mul_sel;
    end else if (busy) begin
      r      <= tc[RES_W-1:0];
      mplier <= {mplier[MPL_W-2:0], 1'b0};
      cnt    <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        case (sel_q)
          MS_RED_A: a_r <= tc[RES_W-1:0];
          MS_RED_B: b_r <= tc[RES_W-1:0];
          MS_P_P:   p   <= tc[RES_W-1:0];
          default:  acc <= tc[RES_W-1:0];
        endcase
      end
    end
    if (cmd.pow_init) begin
      acc   <= ONE;
      p     <= cmd.pow_base_b ? b_r : a_r;
      e_reg <= cmd.pow_exp_fermat ? FERMAT : e_in;
    end else if (cmd.e_shift) begin
      e_reg <= e_reg >> 1;
    end
    if (cmd.out_load) begin
      residue      <= res_mux[OUT_W-1:0];
      compare_flag <= flag_mux;
    end
  end

  always_comb begin
    sum_ab   = MPL_W'(a_r) + MPL_W'(b_r);
    sub_ab   = (a_r >= b_r) ? MPL_W'(a_r) - MPL_W'(b_r)
                            : MPL_W'(a_r) + MOD_M - MPL_W'(b_r);
    res_mux  = '0;
    flag_mux = 1'b0;
    case (cmd.res_sel)
      RS_ACC:   res_mux = acc;
      RS_RAW:   res_mux = (raw[RAW_W-1] && acc != '0) ? MOD_R - acc : acc;
      RS_ADD:   res_mux = (sum_ab >= MOD_M) ? RES_W'(sum_ab - MOD_M) : RES_W'(sum_ab);
      RS_SUB:   res_mux = sub_ab[RES_W-1:0];
      RS_LESS:  flag_mux = (a_r < b_r);
      RS_EQUAL: flag_mux = (a_r == b_r);
      default:  res_mux = '0;
    endcase
  end

  assign status.mul_done = done;
  assign status.e_zero   = (e_reg == '0);
  assign status.e_lsb    = e_reg[0];

  ap_r_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (r < MOD_R))
    else $error("partial product out of range");
  ap_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("multiplier done without a run");
  ap_no_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !busy)
    else $error("multiplier started while busy");
  ap_acc_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.out_load) && $past(cmd.res_sel) == RS_ACC |-> ({1'b0, residue} < MOD_R))
    else $error("result out of range");

endmodule
`default_nettype wire

>>> sv/mau_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mau_ctrl
// Sequencer of the modular arithmetic unit: operand reduction, operation
// dispatch, square-and-multiply loop and output handshake.
// ---------------------------------------------------------------------------
module mau_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [3:0]        func,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire mau_pkg::status_t  status,
  output mau_pkg::cmd_t          cmd
);
  import mau_pkg::*;

  state_t state, state_next, ret_state, ret_state_next;
  func_t  func_q;
  logic   out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) func_q <= func_t'(func);
  end

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    cmd            = '0;
    cmd.mul_sel    = MS_RED_A;
    cmd.res_sel    = RS_ZERO;
    s_tready       = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_RED_A;
        end
      end
      ST_RED_A: begin
        cmd.mul_start  = 1'b1;
        cmd.mul_sel    = MS_RED_A;
        ret_state_next = ST_RED_B;
        state_next     = ST_WAIT;
      end
      ST_RED_B: begin
        cmd.mul_start  = 1'b1;
        cmd.mul_sel    = MS_RED_B;
        ret_state_next = ST_DISPATCH;
        state_next     = ST_WAIT;
      end
      ST_DISPATCH: begin
        case (func_q)
          FN_REDUCE:  state_next = ST_RED_RAW;
          FN_MUL:     state_next = ST_MUL_AB;
          FN_DIV:     state_next = ST_POW_INIT;
          FN_INVERSE: state_next = ST_POW_INIT;
          FN_POWER:   state_next = ST_POW_INIT;
          default:    state_next = ST_FINISH;
        endcase
      end
      ST_RED_RAW: begin
        cmd.mul_start  = 1'b1;
        cmd.mul_sel    = MS_RED_RAW;
        ret_state_next = ST_FINISH;
        state_next     = ST_WAIT;
      end
      ST_MUL_AB: begin
        cmd.mul_start  = 1'b1;
        cmd.mul_sel    = MS_AB;
        ret_state_next = ST_FINISH;
        state_next     = ST_WAIT;
      end
      ST_POW_INIT: begin
        cmd.pow_init       = 1'b1;
        cmd.pow_base_b     = (func_q == FN_DIV);
        cmd.pow_exp_fermat = (func_q != FN_POWER);
        state_next         = ST_POW_STEP;
      end
      ST_POW_STEP: begin
        if (status.e_zero) begin
          state_next = (func_q == FN_DIV) ? ST_DIV_MUL : ST_FINISH;
        end else if (status.e_lsb) begin
          cmd.mul_start  = 1'b1;
          cmd.mul_sel    = MS_ACC_P;
          ret_state_next = ST_POW_SQR;
          state_next     = ST_WAIT;
        end else begin
          state_next = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        cmd.mul_start  = 1'b1;
        cmd.mul_sel    = MS_P_P;
        cmd.e_shift    = 1'b1;
        ret_state_next = ST_POW_STEP;
        state_next     = ST_WAIT;
      end
      ST_DIV_MUL: begin
        cmd.mul_start  = 1'b1;
        cmd.mul_sel    = MS_A_ACC;
        ret_state_next = ST_FINISH;
        state_next     = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.mul_done) state_next = ret_state;
      end
      ST_FINISH: begin
        case (func_q)
          FN_REDUCE:  cmd.res_sel = RS_RAW;
          FN_ADD:     cmd.res_sel = RS_ADD;
          FN_SUB:     cmd.res_sel = RS_SUB;
          FN_MUL:     cmd.res_sel = RS_ACC;
          FN_DIV:     cmd.res_sel = RS_ACC;
          FN_INVERSE: cmd.res_sel = RS_ACC;
          FN_POWER:   cmd.res_sel = RS_ACC;
          FN_LESS:    cmd.res_sel = RS_LESS;
          FN_EQUAL:   cmd.res_sel = RS_EQUAL;
          default:    cmd.res_sel = RS_ZERO;
        endcase
        // hold until the output register is free
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load)  out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  assign m_tvalid = out_valid;

  ap_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_RED_A)
    else $error("accept did not start reduction");
  ap_load_safe: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("result overwritten before taken");
  ap_wait_ret: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |-> ret_state != ST_WAIT && ret_state != ST_IDLE)
    else $error("bad return state");

endmodule
`default_nettype wire

>>> sv/modular_arithmetic_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular arithmetic over a prime modulus: reduce, add, sub, mul, div,
// inverse, power and compare, on one shared bit-serial modular multiplier.
// ---------------------------------------------------------------------------
// Each modular product is a start, a scan of the 32 multiplier bits and a
// done handoff; both operands are reduced first, and power runs up to 62
// products. One item is in work at a time; the output register frees the
// input as soon as the result is loaded.
// Reset: synchronous, clears the sequencer and the output valid flag.
// ---------------------------------------------------------------------------
module modular_arithmetic_unit #(
  parameter int unsigned MODULUS = 998244353
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // operand_a[29:0], operand_b[59:30], raw_integer[91:60], exponent[122:92]
  input  wire logic [127:0]  s_tdata,
  // func[3:0]
  input  wire logic [3:0]    s_tuser,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // residue[29:0]
  output logic [31:0]        m_tdata,
  // compare_flag[0]
  output logic               m_tuser
);
  import mau_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [29:0] residue;

  mau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mau_datapath #(.MODULUS(MODULUS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .operand_a    (s_tdata[29:0]),
    .operand_b    (s_tdata[59:30]),
    .raw_integer  (s_tdata[91:60]),
    .exponent     (s_tdata[122:92]),
    .cmd          (cmd),
    .status       (status),
    .residue      (residue),
    .compare_flag (m_tuser)
  );

  assign m_tdata = {2'b00, residue};

endmodule
`default_nettype wire

>>> bench/modular_arithmetic_unit_checker.sv
// ---------------------------------------------------------------------------
// modular_arithmetic_unit_checker
// Watches both stream channels of the modular arithmetic unit, computes the
// expected residue and compare flag for every accepted item and checks each
// result item against the oldest expectation in order.
// ---------------------------------------------------------------------------
module modular_arithmetic_unit_checker #(
  parameter longint unsigned MODULUS = 998244353
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic [3:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [31:0]  m_tdata,
  input  logic         m_tuser,
  output int           fail_count,
  output int           pending,
  output int           result_count
);
  import mau_pkg::*;

  typedef struct packed {
    logic [29:0] residue;
    logic        flag;
  } answer_t;

  answer_t answers_due[$];

  function automatic longint unsigned mul_mod(longint unsigned x, longint unsigned y);
    return (x * y) % MODULUS;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base,
                                              longint unsigned pwr);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1 % MODULUS;
    sq = base;
    while (pwr != 0) begin
      if (pwr[0]) acc = mul_mod(acc, sq);
      sq = mul_mod(sq, sq);
      pwr = pwr >> 1;
    end
    return acc;
  endfunction

  function automatic answer_t compute_answer(logic [3:0] fn, logic [127:0] d);
    longint unsigned a;
    longint unsigned b;
    longint          v;
    answer_t         r;
    a = longint'(d[29:0]) % MODULUS;
    b = longint'(d[59:30]) % MODULUS;
    r = '0;
    case (fn)
      FN_REDUCE: begin
        v = longint'($signed(d[91:60])) % longint'(MODULUS);
        if (v < 0) v = v + longint'(MODULUS);
        r.residue = v[29:0];
      end
      FN_ADD:     r.residue = 30'((a + b) >= MODULUS ? a + b - MODULUS : a + b);
      FN_SUB:     r.residue = 30'((a >= b) ? a - b : a + MODULUS - b);
      FN_MUL:     r.residue = 30'(mul_mod(a, b));
      FN_DIV:     r.residue = 30'(mul_mod(a, pow_mod(b, MODULUS - 2)));
      FN_INVERSE: r.residue = 30'(pow_mod(a, MODULUS - 2));
      FN_POWER:   r.residue = 30'(pow_mod(a, longint'(d[122:92])));
      FN_LESS:    r.flag = (a < b);
      FN_EQUAL:   r.flag = (a == b);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
      answers_due.delete();
    end else begin
      if (s_tvalid && s_tready)
        answers_due.insert(answers_due.size(), compute_answer(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        result_count <= result_count + 1;
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result residue=%0d flag=%0d", $time, m_tdata[29:0],
                   m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = answers_due.pop_front();
          if (m_tdata !== {2'b00, want.residue} || m_tuser !== want.flag) begin
            $display("%0t: mismatch expected residue=%0d flag=%0d, got residue=%0d flag=%0d",
                     $time, want.residue, want.flag, m_tdata, m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = answers_due.size();

endmodule

>>> bench/modular_arithmetic_unit_tb.sv
// ---------------------------------------------------------------------------
// modular_arithmetic_unit_tb
// Drives directed and random items of every operation through the modular
// arithmetic unit with random idling on both sides; a checker compares.
// ---------------------------------------------------------------------------
module modular_arithmetic_unit_tb;
  import mau_pkg::*;

  localparam int unsigned PRIME = 998244353;
  localparam int RANDOM_ITEMS = 930;
  localparam int IDLE_LIMIT = 20000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [31:0]  m_tdata;
  logic         m_tuser;
  int           fail_count;
  int           pending;
  int           result_count;
  int           idle_cycles = 0;
  int           cycle = 0;
  int           sent = 0;
  bit           calm = 0;

  always #4 clk = ~clk;

  modular_arithmetic_unit #(.MODULUS(PRIME)) dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  modular_arithmetic_unit_checker #(.MODULUS(PRIME)) checker_i (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .fail_count, .pending, .result_count
  );

  // hold ready low about 30% of cycles except in the calm stretch
  always @(posedge clk) begin
    cycle <= cycle + 1;
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d cycles", cycle);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [29:0] pick_residue();
    case ($urandom_range(9))
      0: return 30'd0;
      1: return 30'd1;
      2: return 30'(PRIME - 1);
      3: return 30'($urandom_range(PRIME - 1, PRIME - 20));
      4: return 30'($urandom);  // may exceed the modulus
      default: return 30'($urandom_range(PRIME - 1));
    endcase
  endfunction

  // drop valid only while idling, so back-to-back items keep it high
  task automatic send_item(logic [3:0] fn, logic [29:0] a, logic [29:0] b,
                           logic [31:0] raw, logic [30:0] pwr);
    while (!calm && $urandom_range(99) < 30) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= fn;
    s_tdata <= {5'd0, pwr, raw, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  initial begin
    logic [29:0] top;
    top = 30'(PRIME - 1);
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_item(FN_REDUCE, 0, 0, 32'h8000_0000, 0);
    send_item(FN_REDUCE, 0, 0, 32'h7fff_ffff, 0);
    send_item(FN_REDUCE, 0, 0, 32'hffff_ffff, 0);
    send_item(FN_REDUCE, 0, 0, 32'(PRIME), 0);
    send_item(FN_ADD, top, top, 0, 0);
    send_item(FN_ADD, 30'h3fff_ffff, 30'h3fff_ffff, 0, 0);
    send_item(FN_SUB, 0, top, 0, 0);
    send_item(FN_SUB, top, 0, 0, 0);
    send_item(FN_MUL, top, top, 0, 0);
    send_item(FN_MUL, 30'h3fff_ffff, 30'(PRIME), 0, 0);
    send_item(FN_DIV, 5, 0, 0, 0);
    send_item(FN_DIV, top, 2, 0, 0);
    send_item(FN_INVERSE, 0, 0, 0, 0);
    send_item(FN_INVERSE, top, 0, 0, 0);
    send_item(FN_POWER, 0, 0, 0, 0);
    send_item(FN_POWER, top, 0, 0, 31'h7fff_ffff);
    send_item(FN_POWER, 3, 0, 0, 31'(PRIME - 1));
    send_item(FN_LESS, 1, 30'(PRIME + 1), 0, 0);
    send_item(FN_LESS, 0, top, 0, 0);
    send_item(FN_EQUAL, 30'(PRIME), 0, 0, 0);
    send_item(FN_EQUAL, 7, 8, 0, 0);
    send_item(4'd9, 3, 4, 0, 0);
    send_item(4'd15, top, top, 32'hffff_ffff, 31'h7fff_ffff);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 400 && i < 500);
      send_item((i % 60 == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8)),
                pick_residue(), pick_residue(), $urandom,
                ($urandom_range(3) == 0) ? 31'($urandom_range(40)) : 31'($urandom));
    end
    s_tvalid <= 0;
    calm = 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d items across all nine operations and unused codes", sent);
    $display("checked %0d results under random stalls on both channels", result_count);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
